/* hdl/timestamp_tag_matcher_assert.svh */
// Assertion macros shared by the timestamp tag matcher checkers.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef TIMESTAMP_TAG_MATCHER_ASSERT_SVH
`define TIMESTAMP_TAG_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timestamp_tag_matcher: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timestamp_tag_matcher: next-cycle check failed");

`endif

/* hdl/ttm_pkg.sv */
// Shared constants, codes and types of the timestamp tag matcher.
// Used by ttm_cell, the top level and the checker; depends on nothing.
package ttm_pkg;

  localparam int TAG_DEPTH_DEF  = 256;
  localparam int PEND_DEPTH_DEF = 16;

  localparam int STAMP_W  = 63;
  localparam int HANDLE_W = 16;
  localparam int STREAM_W = 2;
  localparam int KIND_W   = 2;
  localparam int REQ_W    = 2;
  localparam int TIME_W   = 32;
  localparam int TOL_W    = 31;
  localparam int TMO_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TAG   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FRAME = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ROUTED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;

  localparam logic [TOL_W-1:0] TOL_RST = 31'd1000;
  localparam logic [TMO_W-1:0] TMO_RST = 16'd10;

  // One tag moving along the chain.
  typedef struct packed {
    logic               v;
    logic [STAMP_W-1:0] stamp;
    logic               flag;
  } ttm_tag_t;

  // One pending frame held by a cell.
  typedef struct packed {
    logic                valid;
    logic [STAMP_W-1:0]  stamp;
    logic [HANDLE_W-1:0] handle;
    logic [STREAM_W-1:0] stream;
    logic [TIME_W-1:0]   deadline;
  } ttm_entry_t;

  // Controls from the sequencer to a row of cells.
  typedef struct packed {
    logic              clr_best;
    logic              load;
    logic              force_load;
    logic              drop;
    logic              shift;
    logic [TOL_W-1:0]  tol;
    logic [TIME_W-1:0] time_now;
  } ttm_cell_ctl_t;

  // Verdict of a cell after a scan.
  typedef struct packed {
    logic match;
    logic flag;
    logic overdue;
  } ttm_cell_stat_t;

endpackage

/* hdl/timestamp_tag_matcher.sv */
// Top level of the timestamp tag matcher: tag ring memory, sequencer, cell chain.
// Depends on ttm_pkg and ttm_cell.
//
// Tags are kept in a ring memory of TAG_DEPTH entries; pending frames sit in a
// chain of PEND_DEPTH cells through which every stored tag is streamed, oldest
// first, one tag per cycle. A tick only advances the time counter. A frame item
// reads the whole ring, waits for the last tag to pass along the chain, and is
// then routed, dropped as full or loaded into the first free cell. A tag item
// streams the ring the same way; after the scan the sequencer walks the cells
// twice (routed frames, then overdue ones), one cell per cycle unless a result
// waits on a full output register, then drops the released frames and closes
// the gaps they left. Results leave through an output register, which stalls
// the sequencer only while it holds a result that waits for its transfer.
module timestamp_tag_matcher #(
  parameter int TAG_DEPTH  = ttm_pkg::TAG_DEPTH_DEF,
  parameter int PEND_DEPTH = ttm_pkg::PEND_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ttm_pkg::REQ_W-1:0]         in_req_type,
  input  logic [ttm_pkg::STAMP_W-1:0]       in_stamp_us,
  input  logic                              in_tag_is_this,
  input  logic [ttm_pkg::HANDLE_W-1:0]      in_frame_handle,
  input  logic [ttm_pkg::STREAM_W-1:0]      in_stream_sel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ttm_pkg::HANDLE_W-1:0]      out_handle,
  output logic [ttm_pkg::STREAM_W-1:0]      out_stream,
  output logic [ttm_pkg::KIND_W-1:0]        out_kind,
  output logic                              out_route_this,
  output logic                              out_last_result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(TAG_DEPTH);
  localparam int CW = $clog2(TAG_DEPTH + 1);
  localparam int IW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int DW = $clog2(PEND_DEPTH + 2);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_FRAME   = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;
  localparam logic [2:0] ST_DROP    = 3'd5;
  localparam logic [2:0] ST_COMPACT = 3'd6;

  logic [2:0]                    state_r, state_nxt;
  logic                          is_tag_r, is_tag_nxt;
  logic [CW-1:0]                 scan_r, scan_nxt;
  logic [DW-1:0]                 cnt_r, cnt_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic                          pass_r, pass_nxt;
  logic [AW-1:0]                 head_r, head_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [ttm_pkg::TIME_W-1:0]    time_r, time_nxt;
  logic [ttm_pkg::TOL_W-1:0]     tol_r;
  logic [ttm_pkg::TMO_W-1:0]     tmo_r;

  logic                          in_acc;
  logic                          acc_tag;
  logic                          acc_frame;
  logic                          acc_tick;
  logic [CW:0]                   wsum;
  logic [AW-1:0]                 wslot;
  logic [CW:0]                   rsum;
  logic [AW-1:0]                 raddr;
  logic                          rd_en;

  logic [ttm_pkg::STAMP_W:0]     mem [TAG_DEPTH];
  logic [ttm_pkg::STAMP_W:0]     rd_data_r;
  logic                          rd_v_r;

  ttm_pkg::ttm_cell_ctl_t        chain_ctl;
  ttm_pkg::ttm_cell_ctl_t        probe_ctl;
  ttm_pkg::ttm_tag_t             mem_tag;
  ttm_pkg::ttm_entry_t           probe_new;
  ttm_pkg::ttm_entry_t           probe_entry;
  ttm_pkg::ttm_cell_stat_t       probe_stat;
  ttm_pkg::ttm_tag_t             tag_fwd   [PEND_DEPTH];
  ttm_pkg::ttm_entry_t           cell_ent  [PEND_DEPTH];
  ttm_pkg::ttm_cell_stat_t       cell_stat [PEND_DEPTH];
  logic [PEND_DEPTH-1:0]         hole;
  logic [PEND_DEPTH-1:0]         m_route;
  logic [PEND_DEPTH-1:0]         m_late;

  logic                          out_valid_r;
  logic [ttm_pkg::HANDLE_W-1:0]  out_handle_r;
  logic [ttm_pkg::STREAM_W-1:0]  out_stream_r;
  logic [ttm_pkg::KIND_W-1:0]    out_kind_r;
  logic                          out_route_r;
  logic                          out_last_r;
  logic                          out_free;
  logic                          out_load;
  logic [ttm_pkg::HANDLE_W-1:0]  ld_handle;
  logic [ttm_pkg::STREAM_W-1:0]  ld_stream;
  logic [ttm_pkg::KIND_W-1:0]    ld_kind;
  logic                          ld_route;
  logic                          ld_last;
  logic                          emit_bit;
  logic                          later_bits;
  logic                          chain_load;
  logic                          chain_drop;
  logic                          chain_shift;

  // Input transfer decoding; nothing is taken while reset is held.
  assign in_ready  = rst_n && (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign acc_tag   = in_acc && (in_req_type == ttm_pkg::REQ_TAG);
  assign acc_frame = in_acc && (in_req_type == ttm_pkg::REQ_FRAME);
  assign acc_tick  = in_acc && (in_req_type == ttm_pkg::REQ_TICK);
  assign cfg_ready = rst_n;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= ttm_pkg::TOL_RST;
      tmo_r <= ttm_pkg::TMO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttm_pkg::CFG_TOLERANCE: tol_r <= cfg_data[ttm_pkg::TOL_W-1:0];
        ttm_pkg::CFG_TIMEOUT:   tmo_r <= cfg_data[ttm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring slot for a new tag (append while filling, else overwrite the oldest) and the scan read address.
  always_comb begin
    wsum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (wsum >= (CW+1)'(TAG_DEPTH)) begin
      wsum = wsum - (CW+1)'(TAG_DEPTH);
    end
    wslot = AW'(wsum);
    rsum = (CW+1)'(head_r) + (CW+1)'(scan_r);
    if (rsum >= (CW+1)'(TAG_DEPTH)) begin
      rsum = rsum - (CW+1)'(TAG_DEPTH);
    end
    raddr = AW'(rsum);
  end

  // Ring pointers and time counter.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    time_nxt  = time_r;
    if (acc_tag) begin
      if (count_r < CW'(TAG_DEPTH)) begin
        count_nxt = count_r + CW'(1);
      end else if (head_r == AW'(TAG_DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + AW'(1);
      end
    end
    if (acc_tick) begin
      time_nxt = time_r + ttm_pkg::TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      time_r  <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      time_r  <= time_nxt;
    end
  end

  // Tag ring memory: written on a tag transfer, read once per scan cycle while unread tags remain.
  assign rd_en = (state_r == ST_SCAN) && (scan_r < count_r);

  always_ff @(posedge clk) begin
    if (acc_tag) begin
      mem[wslot] <= {in_tag_is_this, in_stamp_us};
    end
    if (rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
    end
  end

  assign mem_tag.v     = rd_v_r;
  assign mem_tag.stamp = rd_data_r[ttm_pkg::STAMP_W-1:0];
  assign mem_tag.flag  = rd_data_r[ttm_pkg::STAMP_W];

  // Controls for the probe cell and the pending chain.
  always_comb begin
    probe_ctl.clr_best   = acc_frame;
    probe_ctl.load       = acc_frame;
    probe_ctl.force_load = 1'b1;
    probe_ctl.drop       = 1'b0;
    probe_ctl.shift      = 1'b0;
    probe_ctl.tol        = tol_r;
    probe_ctl.time_now   = time_r;

    chain_ctl.clr_best   = acc_tag;
    chain_ctl.load       = chain_load;
    chain_ctl.force_load = 1'b0;
    chain_ctl.drop       = chain_drop;
    chain_ctl.shift      = chain_shift;
    chain_ctl.tol        = tol_r;
    chain_ctl.time_now   = time_r;

    probe_new.valid    = 1'b1;
    probe_new.stamp    = in_stamp_us;
    probe_new.handle   = in_frame_handle;
    probe_new.stream   = in_stream_sel;
    probe_new.deadline = time_r + ttm_pkg::TIME_W'(tmo_r);
  end

  // Probe cell: looks up the nearest tag for an arriving frame.
  ttm_cell u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (probe_ctl),
    .tag_in    (mem_tag),
    .tag_out   (),
    .new_entry (probe_new),
    .up_entry  ('0),
    .hole_in   (1'b0),
    .hole_out  (),
    .entry_out (probe_entry),
    .stat_out  (probe_stat)
  );

  // Pending chain: tags ripple upward, entries move down to close gaps.
  for (genvar gi = 0; gi < PEND_DEPTH; gi++) begin : g_cell
    ttm_pkg::ttm_tag_t   c_tag_in;
    ttm_pkg::ttm_entry_t c_up;
    logic                c_hole_in;

    if (gi == 0) begin : g_first
      assign c_tag_in  = mem_tag;
      assign c_hole_in = 1'b0;
    end else begin : g_rest
      assign c_tag_in  = tag_fwd[gi-1];
      assign c_hole_in = hole[gi-1];
    end

    if (gi == PEND_DEPTH - 1) begin : g_top
      assign c_up = '0;
    end else begin : g_mid
      assign c_up = cell_ent[gi+1];
    end

    ttm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (chain_ctl),
      .tag_in    (c_tag_in),
      .tag_out   (tag_fwd[gi]),
      .new_entry (probe_entry),
      .up_entry  (c_up),
      .hole_in   (c_hole_in),
      .hole_out  (hole[gi]),
      .entry_out (cell_ent[gi]),
      .stat_out  (cell_stat[gi])
    );

    assign m_route[gi] = cell_ent[gi].valid && cell_stat[gi].match;
    assign m_late[gi]  = cell_ent[gi].valid && !cell_stat[gi].match && cell_stat[gi].overdue;
  end

  // Output staging and the result chosen by the walk.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    emit_bit   = pass_r ? m_late[idx_r] : m_route[idx_r];
    later_bits = 1'b0;
    for (int j = 0; j < PEND_DEPTH; j++) begin
      if (j > int'(idx_r)) begin
        later_bits = later_bits | (pass_r ? m_late[j] : m_route[j]);
      end
    end
    if (!pass_r) begin
      later_bits = later_bits | (|m_late);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    is_tag_nxt  = is_tag_r;
    scan_nxt    = scan_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pass_nxt    = pass_r;
    chain_load  = 1'b0;
    chain_drop  = 1'b0;
    chain_shift = 1'b0;
    out_load    = 1'b0;
    ld_handle   = probe_entry.handle;
    ld_stream   = probe_entry.stream;
    ld_kind     = ttm_pkg::KIND_ROUTED;
    ld_route    = 1'b0;
    ld_last     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (acc_tag || acc_frame) begin
          state_nxt  = ST_SCAN;
          is_tag_nxt = acc_tag;
          scan_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          scan_nxt = scan_r + CW'(1);
        end else begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == DW'(PEND_DEPTH + 1)) begin
          state_nxt = is_tag_r ? ST_EMIT : ST_FRAME;
          idx_nxt   = '0;
          pass_nxt  = 1'b0;
        end else begin
          cnt_nxt = cnt_r + DW'(1);
        end
      end
      ST_FRAME: begin
        if (probe_stat.match) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_kind   = ttm_pkg::KIND_ROUTED;
            ld_route  = probe_stat.flag;
            state_nxt = ST_IDLE;
          end
        end else if (cell_ent[PEND_DEPTH-1].valid) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_kind   = ttm_pkg::KIND_FULL;
            state_nxt = ST_IDLE;
          end
        end else begin
          chain_load = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EMIT: begin
        ld_handle = cell_ent[idx_r].handle;
        ld_stream = cell_ent[idx_r].stream;
        ld_kind   = pass_r ? ttm_pkg::KIND_TIMEOUT : ttm_pkg::KIND_ROUTED;
        ld_route  = pass_r ? 1'b0 : cell_stat[idx_r].flag;
        ld_last   = !later_bits;
        if (!emit_bit || out_free) begin
          out_load = emit_bit;
          if (idx_r == IW'(PEND_DEPTH - 1)) begin
            idx_nxt = '0;
            if (pass_r) begin
              state_nxt = ST_DROP;
            end else begin
              pass_nxt = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      ST_DROP: begin
        chain_drop = 1'b1;
        state_nxt  = ST_COMPACT;
        cnt_nxt    = '0;
      end
      ST_COMPACT: begin
        chain_shift = 1'b1;
        if (cnt_r == DW'(PEND_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + DW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      is_tag_r <= 1'b0;
      scan_r   <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
      pass_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      is_tag_r <= is_tag_nxt;
      scan_r   <= scan_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      pass_r   <= pass_nxt;
    end
  end

  // Output register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_handle_r <= ld_handle;
      out_stream_r <= ld_stream;
      out_kind_r   <= ld_kind;
      out_route_r  <= ld_route;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_handle      = out_handle_r;
  assign out_stream      = out_stream_r;
  assign out_kind        = out_kind_r;
  assign out_route_this  = out_route_r;
  assign out_last_result = out_last_r;

endmodule

/* hdl/ttm_cell.sv */
// One cell of the matcher chain: holds a pending frame and its best tag so far.
// Depends on ttm_pkg for the entry, tag, control and status types.
module ttm_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ttm_pkg::ttm_cell_ctl_t  ctl,
  input  ttm_pkg::ttm_tag_t       tag_in,
  output ttm_pkg::ttm_tag_t       tag_out,
  input  ttm_pkg::ttm_entry_t     new_entry,
  input  ttm_pkg::ttm_entry_t     up_entry,
  input  logic                    hole_in,
  output logic                    hole_out,
  output ttm_pkg::ttm_entry_t     entry_out,
  output ttm_pkg::ttm_cell_stat_t stat_out
);

  logic                          valid_r;
  logic [ttm_pkg::STAMP_W-1:0]   stamp_r;
  logic [ttm_pkg::HANDLE_W-1:0]  handle_r;
  logic [ttm_pkg::STREAM_W-1:0]  stream_r;
  logic [ttm_pkg::TIME_W-1:0]    deadline_r;
  logic                          found_r;
  logic [ttm_pkg::STAMP_W-1:0]   bdist_r;
  logic [ttm_pkg::STAMP_W-1:0]   bstamp_r;
  logic                          bflag_r;
  ttm_pkg::ttm_tag_t             tag_r;

  logic [ttm_pkg::STAMP_W-1:0]   gap;
  logic                          take;
  logic                          match;
  logic                          overdue;
  logic [ttm_pkg::TIME_W-1:0]    tdiff;
  logic                          do_load;
  logic                          do_shift;

  // Distance to the passing tag and whether it beats the best so far.
  // Distance ties go to the larger stamp; equal stamps go to the later, newest ring entry.
  always_comb begin
    gap  = (tag_in.stamp >= stamp_r) ? (tag_in.stamp - stamp_r)
                                     : (stamp_r - tag_in.stamp);
    take = tag_in.v && (!found_r || (gap < bdist_r) ||
                        ((gap == bdist_r) && (tag_in.stamp >= bstamp_r)));
  end

  // Verdict: matched within tolerance, or past the deadline by signed difference.
  always_comb begin
    match    = found_r && (bdist_r <= {{(ttm_pkg::STAMP_W-ttm_pkg::TOL_W){1'b0}}, ctl.tol});
    tdiff    = ctl.time_now - deadline_r;
    overdue  = (tdiff != '0) && !tdiff[ttm_pkg::TIME_W-1];
    hole_out = hole_in | !valid_r;
    do_load  = ctl.load && (ctl.force_load || (!hole_in && !valid_r));
    do_shift = ctl.shift && hole_out;
  end

  // Occupancy: load into the first free cell, close holes, retire finished frames.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (do_load) begin
      valid_r <= 1'b1;
    end else if (do_shift) begin
      valid_r <= up_entry.valid;
    end else if (ctl.drop) begin
      valid_r <= valid_r & !match & !overdue;
    end
  end

  // Frame payload.
  always_ff @(posedge clk) begin
    if (do_load) begin
      stamp_r    <= new_entry.stamp;
      handle_r   <= new_entry.handle;
      stream_r   <= new_entry.stream;
      deadline_r <= new_entry.deadline;
    end else if (do_shift) begin
      stamp_r    <= up_entry.stamp;
      handle_r   <= up_entry.handle;
      stream_r   <= up_entry.stream;
      deadline_r <= up_entry.deadline;
    end
  end

  // Best tag tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clr_best) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bdist_r  <= gap;
      bstamp_r <= tag_in.stamp;
      bflag_r  <= tag_in.flag;
    end
  end

  // Hand the tag on to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.v <= 1'b0;
    end else begin
      tag_r.v <= tag_in.v;
    end
  end

  always_ff @(posedge clk) begin
    tag_r.stamp <= tag_in.stamp;
    tag_r.flag  <= tag_in.flag;
  end

  assign tag_out = tag_r;

  assign entry_out.valid    = valid_r;
  assign entry_out.stamp    = stamp_r;
  assign entry_out.handle   = handle_r;
  assign entry_out.stream   = stream_r;
  assign entry_out.deadline = deadline_r;

  assign stat_out.match   = match;
  assign stat_out.flag    = bflag_r;
  assign stat_out.overdue = overdue;

endmodule

/* hdl/ttm_checker.sv */
// Port-level checks of the timestamp tag matcher, bound to the top level.
// Depends on ttm_pkg and the macros in timestamp_tag_matcher_assert.svh.
`include "timestamp_tag_matcher_assert.svh"

module ttm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ttm_pkg::REQ_W-1:0]     in_req_type,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ttm_pkg::HANDLE_W-1:0]  out_handle,
  input logic [ttm_pkg::STREAM_W-1:0]  out_stream,
  input logic [ttm_pkg::KIND_W-1:0]    out_kind,
  input logic                          out_route_this,
  input logic                          out_last_result
);

  // A stalled result holds until its transfer.
  `TTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_handle) && $stable(out_stream) && $stable(out_kind))

  // Dropped frames never carry a route.
  `TTM_ASSERT_NOW(a_drop_no_route, out_valid && (out_kind != ttm_pkg::KIND_ROUTED), !out_route_this)

  // A full-store drop is the only result of its frame.
  `TTM_ASSERT_NOW(a_full_last, out_valid && (out_kind == ttm_pkg::KIND_FULL), out_last_result)

  // A tick leaves the input ready again in the next cycle.
  `TTM_ASSERT_NEXT(a_tick_quick, in_valid && in_ready && (in_req_type == ttm_pkg::REQ_TICK), in_ready)

endmodule

bind timestamp_tag_matcher ttm_checker u_ttm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_handle      (out_handle),
  .out_stream      (out_stream),
  .out_kind        (out_kind),
  .out_route_this  (out_route_this),
  .out_last_result (out_last_result)
);
